[hdl/sli_pkg.sv]
// shared types and constants for the sorted list intersection block
// no dependencies; used by every file under hdl
package sli_pkg;

   localparam int DOC_BITS         = 31;
   localparam int LANE_BITS        = 4;
   localparam int COUNT_BITS       = 5;
   localparam int MAX_LANES_DEF    = 16;
   localparam int LANE_COUNT_RESET = 2;

   localparam logic [DOC_BITS-1:0] DOC_MAX = {DOC_BITS{1'b1}};

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_NEXT    = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_REPLY   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_ACK        = 3'd0,
      KIND_REQ        = 3'd1,
      KIND_MATCH      = 3'd2,
      KIND_EXHAUSTED  = 3'd3,
      KIND_UNEXPECTED = 3'd4
   } kind_type;

   typedef struct packed {
      op_type                opcode;
      logic [LANE_BITS-1:0]  lane;
      logic [DOC_BITS-1:0]   doc_id;
   } req_item_type;

   typedef struct packed {
      kind_type              kind;
      logic [LANE_BITS-1:0]  req_lane;
      logic [DOC_BITS-1:0]   value;
   } rsp_item_type;

endpackage

[hdl/sli_head_mem.sv]
// lane head memory: one write port, one registered read port, write-first forwarding
// unwritten entries read as zero through per-entry valid bits cleared by reset
// depends on sli_pkg
module sli_head_mem #(
   parameter int DEPTH = sli_pkg::MAX_LANES_DEF,
   parameter int AW    = sli_pkg::LANE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [sli_pkg::DOC_BITS-1:0]  wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [sli_pkg::DOC_BITS-1:0]  rd_data
);

   logic [sli_pkg::DOC_BITS-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]             valid_ff;
   logic [sli_pkg::DOC_BITS-1:0] rd_data_ff;
   logic                         rd_valid_ff;
   logic                         same_addr;

   assign same_addr = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // a read of the entry being written sees the new value
      rd_data_ff <= same_addr ? wr_data : mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= same_addr | valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

[hdl/sorted_list_intersection.sv]
// sorted_list_intersection: leapfrog intersection of ascending doc-id lanes
// depends on sli_pkg and sli_head_mem
//
//   port group    direction  flow control         carries
//   req_*/start   in         start & !busy       req_item_type item
//   rsp_*         out        rsp_strobe, 1 cycle rsp_item_type item
//   csr_*         in         csr_valid/ready     lane_count (5 bits)
//
// load, advance (after the first search), unexpected and reply-with-zero items
// answer on the cycle after acceptance with busy never raised.
// searches read one lane head per cycle from the head memory: each scan pass
// reads the active lanes in turn and ends with an agreement sweep over them,
// with at most four passes before the search reports exhaustion.
// next after the first search first reads lane 0's head in the S_HEAD0 state.
// reset is synchronous and clears all lane heads; results cannot be stalled.
module sorted_list_intersection #(
   parameter int MAX_LANES = sli_pkg::MAX_LANES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  sli_pkg::req_item_type            req_payload,
   output logic                             rsp_strobe,
   output sli_pkg::rsp_item_type            rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sli_pkg::COUNT_BITS-1:0]   csr_data
);

   localparam int DW = sli_pkg::DOC_BITS;
   localparam int LW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
   localparam int NW = $clog2(MAX_LANES + 1);
   localparam int EW = (NW > sli_pkg::COUNT_BITS) ? NW : sli_pkg::COUNT_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_HEAD0,
      S_SCAN,
      S_CHECK
   } state_type;

   state_type                       state_ff, state_in;
   logic                            first_ff, first_in;
   logic                            more_ff, more_in;
   logic [DW-1:0]                   goal_ff, goal_in;
   logic [DW-1:0]                   top_ff, top_in;
   logic [NW-1:0]                   pos_ff, pos_in;
   logic                            await_ff, await_in;
   logic                            restart_ff, restart_in;
   logic [LW-1:0]                   ptr_ff, ptr_in;
   logic [1:0]                      pass_ff, pass_in;
   logic [sli_pkg::COUNT_BITS-1:0]  lane_count_ff;
   logic                            rsp_strobe_ff, rsp_strobe_in;
   sli_pkg::rsp_item_type           rsp_ff, rsp_in;

   logic                            wr_en;
   logic [LW-1:0]                   wr_addr;
   logic [DW-1:0]                   wr_data;
   logic [LW-1:0]                   rd_addr;
   logic [DW-1:0]                   cand;

   logic [EW-1:0]                   cnt_ext, max_ext, n_ext, lane_ext, pos_ext;
   logic [EW-1:0]                   ptr_ext, ptr_inc_ext, scan_start;
   logic                            n_zero, last, accept;
   logic                            go_scan, go_check, do_exh;
   logic [DW-1:0]                   top_new, goal_new;
   logic                            behind;

   function automatic sli_pkg::rsp_item_type make_rsp(
      input sli_pkg::kind_type k,
      input logic [EW-1:0]     l,
      input logic [DW-1:0]     v
   );
      sli_pkg::rsp_item_type r;
      r.kind     = k;
      r.req_lane = l[sli_pkg::LANE_BITS-1:0];
      r.value    = v;
      return r;
   endfunction

   sli_head_mem #(
      .DEPTH (MAX_LANES),
      .AW    (LW)
   ) u_heads (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (cand)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   assign cnt_ext     = EW'(lane_count_ff);
   assign max_ext     = EW'(MAX_LANES);
   assign n_ext       = (cnt_ext > max_ext) ? max_ext : cnt_ext;
   assign n_zero      = (n_ext == '0);
   assign lane_ext    = EW'(req_payload.lane);
   assign pos_ext     = EW'(pos_ff);
   assign ptr_ext     = EW'(ptr_ff);
   assign ptr_inc_ext = ptr_ext + EW'(1);
   assign last        = (ptr_inc_ext >= n_ext);

   // leapfrog step on the head under evaluation
   assign top_new  = (cand > top_ff) ? cand : top_ff;
   assign goal_new = (top_new > goal_ff) ? top_new : goal_ff;
   assign behind   = (cand < goal_new);

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      more_in       = more_ff;
      goal_in       = goal_ff;
      top_in        = top_ff;
      pos_in        = pos_ff;
      await_in      = await_ff;
      restart_in    = restart_ff;
      ptr_in        = ptr_ff;
      pass_in       = pass_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = lane_ext[LW-1:0];
      wr_data       = req_payload.doc_id;
      rd_addr       = '0;
      go_scan       = 1'b0;
      go_check      = 1'b0;
      do_exh        = 1'b0;
      scan_start    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_payload.opcode)
                  sli_pkg::OP_LOAD: begin
                     rsp_strobe_in = 1'b1;
                     if (await_ff) begin
                        rsp_in = make_rsp(sli_pkg::KIND_UNEXPECTED, '0, '0);
                     end else begin
                        rsp_in = make_rsp(sli_pkg::KIND_ACK, '0, '0);
                        if (lane_ext < n_ext) begin
                           wr_en = 1'b1;
                           if (req_payload.doc_id == '0) begin
                              more_in = 1'b0;
                           end
                        end
                     end
                  end
                  sli_pkg::OP_NEXT: begin
                     if (await_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = make_rsp(sli_pkg::KIND_UNEXPECTED, '0, '0);
                     end else if (n_zero || !more_ff) begin
                        do_exh = 1'b1;
                     end else if (first_ff) begin
                        first_in = 1'b0;
                        goal_in  = DW'(1);
                        top_in   = '0;
                        pass_in  = '0;
                        go_scan  = 1'b1;
                     end else begin
                        // target is lane 0's head plus one
                        rd_addr  = '0;
                        state_in = S_HEAD0;
                     end
                  end
                  sli_pkg::OP_ADVANCE: begin
                     if (await_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = make_rsp(sli_pkg::KIND_UNEXPECTED, '0, '0);
                     end else if (n_zero || !more_ff) begin
                        do_exh = 1'b1;
                     end else begin
                        goal_in = req_payload.doc_id;
                        top_in  = '0;
                        pos_in  = '0;
                        if (first_ff) begin
                           first_in = 1'b0;
                           pass_in  = '0;
                           go_scan  = 1'b1;
                        end else begin
                           await_in      = 1'b1;
                           restart_in    = 1'b1;
                           rsp_strobe_in = 1'b1;
                           rsp_in = make_rsp(sli_pkg::KIND_REQ, '0, req_payload.doc_id);
                        end
                     end
                  end
                  sli_pkg::OP_REPLY: begin
                     if (!await_ff || lane_ext != pos_ext || lane_ext >= max_ext) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = make_rsp(sli_pkg::KIND_UNEXPECTED, '0, '0);
                     end else begin
                        wr_en    = 1'b1;
                        top_in   = req_payload.doc_id;
                        await_in = 1'b0;
                        if (req_payload.doc_id == '0 || n_zero) begin
                           do_exh = 1'b1;
                        end else begin
                           restart_in = 1'b0;
                           pass_in    = '0;
                           scan_start = restart_ff ? '0 : pos_ext + EW'(1);
                           go_scan    = 1'b1;
                        end
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in = make_rsp(sli_pkg::KIND_UNEXPECTED, '0, '0);
                  end
               endcase
            end
         end
         S_HEAD0: begin
            if (cand == sli_pkg::DOC_MAX) begin
               do_exh = 1'b1;
            end else begin
               goal_in       = cand + DW'(1);
               top_in        = '0;
               pos_in        = '0;
               await_in      = 1'b1;
               restart_in    = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_in        = make_rsp(sli_pkg::KIND_REQ, '0, cand + DW'(1));
               state_in      = S_IDLE;
            end
         end
         S_SCAN: begin
            top_in  = top_new;
            goal_in = goal_new;
            if (behind) begin
               pos_in        = NW'(ptr_ext);
               await_in      = 1'b1;
               restart_in    = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_in        = make_rsp(sli_pkg::KIND_REQ, ptr_ext, goal_new);
               state_in      = S_IDLE;
            end else if (last) begin
               go_check = 1'b1;
            end else begin
               ptr_in  = ptr_inc_ext[LW-1:0];
               rd_addr = ptr_inc_ext[LW-1:0];
            end
         end
         S_CHECK: begin
            // sweep lanes 0..n-1 comparing each head against top_ff
            if (cand != top_ff || last) begin
               if (cand == top_ff && top_ff >= goal_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = make_rsp(sli_pkg::KIND_MATCH, '0, top_ff);
                  state_in      = S_IDLE;
               end else if (pass_ff == 2'd3) begin
                  do_exh = 1'b1;
               end else begin
                  pass_in = pass_ff + 2'd1;
                  go_scan = 1'b1;
               end
            end else begin
               ptr_in  = ptr_inc_ext[LW-1:0];
               rd_addr = ptr_inc_ext[LW-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a pass that starts past the last lane goes straight to the agreement sweep
      if (go_scan) begin
         pos_in = '0;
         if (scan_start < n_ext) begin
            ptr_in   = scan_start[LW-1:0];
            rd_addr  = scan_start[LW-1:0];
            state_in = S_SCAN;
         end else begin
            go_check = 1'b1;
         end
      end
      if (go_check) begin
         pos_in   = '0;
         ptr_in   = '0;
         rd_addr  = '0;
         state_in = S_CHECK;
      end
      if (do_exh) begin
         more_in       = 1'b0;
         await_in      = 1'b0;
         restart_in    = 1'b0;
         pos_in        = '0;
         rsp_strobe_in = 1'b1;
         rsp_in        = make_rsp(sli_pkg::KIND_EXHAUSTED, '0, '0);
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         first_ff      <= 1'b1;
         more_ff       <= 1'b1;
         goal_ff       <= '0;
         top_ff        <= '0;
         pos_ff        <= '0;
         await_ff      <= 1'b0;
         restart_ff    <= 1'b0;
         ptr_ff        <= '0;
         pass_ff       <= '0;
         lane_count_ff <= sli_pkg::COUNT_BITS'(sli_pkg::LANE_COUNT_RESET);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_ff      <= first_in;
         more_ff       <= more_in;
         goal_ff       <= goal_in;
         top_ff        <= top_in;
         pos_ff        <= pos_in;
         await_ff      <= await_in;
         restart_ff    <= restart_in;
         ptr_ff        <= ptr_in;
         pass_ff       <= pass_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            lane_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

[hdl/sli_checker.sv]
// port-level checks for sorted_list_intersection, bound to the top level
// depends on sli_pkg and sorted_list_intersection
module sli_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_strobe,
   input sli_pkg::rsp_item_type   rsp_payload
);

   // a result never shows while a search is still running
   a_rsp_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // an accepted item either answers at once or starts a search
   a_accept_moves : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted item produced neither result nor search");

   // a search only ends by giving its result
   a_end_has_rsp : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("search ended without a result");

   // only advance requests and matches carry a lane or a value
   a_zero_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.kind != sli_pkg::KIND_REQ
                  && rsp_payload.kind != sli_pkg::KIND_MATCH)
      |-> (rsp_payload.value == '0 && rsp_payload.req_lane == '0))
      else $error("nonzero fields on a plain result");

endmodule

bind sorted_list_intersection sli_checker u_sli_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
